>>> hw/rtl/i2c_master_bit_engine_top_macros.svh
// assertion macros for the i2c master bit engine
`ifndef I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define I2CMBE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define I2CMBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define I2CMBE_ASSERT_NOW(label, clk, rst, ante, cons)
`define I2CMBE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/i2cmbe_pkg.sv
// types and constants for the i2c master bit engine
`timescale 1ns / 1ps
package i2cmbe_pkg;

   localparam logic [2:0] FUNC_START    = 3'd0;
   localparam logic [2:0] FUNC_STOP     = 3'd1;
   localparam logic [2:0] FUNC_SEND     = 3'd2;
   localparam logic [2:0] FUNC_WAIT_ACK = 3'd3;
   localparam logic [2:0] FUNC_READ     = 3'd4;

   localparam logic [1:0] CSR_LONG_DELAY  = 2'd0;
   localparam logic [1:0] CSR_SHORT_DELAY = 2'd1;
   localparam logic [1:0] CSR_POLL_LIMIT  = 2'd2;

   localparam logic [7:0] LONG_DELAY_RST  = 8'd4;
   localparam logic [7:0] SHORT_DELAY_RST = 8'd2;
   localparam logic [7:0] POLL_LIMIT_RST  = 8'd250;
   localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_TX_HI, PH_TX_LO,
      PH_TX_BIT, PH_WA_HI, PH_WA_POLL, PH_RX_HI, PH_RX_SAMP, PH_AK_HI, PH_AK_LO
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic       ack_after_read;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_failed;
   } rsp_type;

   typedef struct packed {
      logic [7:0] long_delay_us;
      logic [7:0] short_delay_us;
      logic [7:0] ack_poll_limit;
   } cfg_type;

endpackage

>>> hw/rtl/i2c_master_bit_engine_top.sv
// i2c master bit engine: one tick item in, one line-state item out
// an accepted tick item's result item is registered and shows in rsp_data in the next cycle
// throughput: one tick item per cycle while results are taken; the sequencer state advances in a single pass
// a result waiting on rsp_ready stalls req_ready only when it is not taken that cycle
// reset: synchronous, clears sequencer to idle, scl high, sda released, no result pending
// reset loads the delay and poll limit registers with 4, 2 and 250
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_top_macros.svh"
module i2c_master_bit_engine_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cmbe_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cmbe_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata
);

   i2cmbe_pkg::cfg_type cfg_ff, cfg_in;
   i2cmbe_pkg::rsp_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   i2cmbe_pkg::rsp_type res;
   logic                step;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            i2cmbe_pkg::CSR_LONG_DELAY:  cfg_in.long_delay_us  = csr_wdata;
            i2cmbe_pkg::CSR_SHORT_DELAY: cfg_in.short_delay_us = csr_wdata;
            i2cmbe_pkg::CSR_POLL_LIMIT:  cfg_in.ack_poll_limit = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   i2cmbe_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .tick  (req_data),
      .cfg   (cfg_ff),
      .res   (res)
   );

   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = step ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_delay_us  <= i2cmbe_pkg::LONG_DELAY_RST;
         cfg_ff.short_delay_us <= i2cmbe_pkg::SHORT_DELAY_RST;
         cfg_ff.ack_poll_limit <= i2cmbe_pkg::POLL_LIMIT_RST;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `I2CMBE_ASSERT_NEXT(a_step_gives_item, clock, reset, step, rsp_valid_ff)
   `I2CMBE_ASSERT_NOW(a_done_not_busy, clock, reset, rsp_valid_ff && rsp_ff.done_res, !rsp_ff.busy_res)
   `I2CMBE_ASSERT_NOW(a_released_reads_high, clock, reset, rsp_valid_ff && !rsp_ff.sda_drive, rsp_ff.sda_level)

endmodule

>>> hw/rtl/i2cmbe_seq.sv
// bus sequencer: state registers and per-tick next state and line logic
`timescale 1ns / 1ps
module i2cmbe_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  i2cmbe_pkg::req_type tick,
   input  i2cmbe_pkg::cfg_type cfg,
   output i2cmbe_pkg::rsp_type res
);

   i2cmbe_pkg::phase_type phase_ff, phase_in;
   logic [7:0] delay_ff, delay_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] rcv_ff, rcv_in;
   logic [7:0] poll_ff, poll_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       drv_ff, drv_in;
   logic       ackc_ff, ackc_in;
   logic       fail_ff, fail_in;
   logic       done;
   logic       is_idle;
   logic       adv;
   logic [8:0] poll_inc;
   logic       poll_over;
   logic [3:0] bit_inc;
   logic [7:0] shift_rx;

   assign is_idle   = (phase_ff == i2cmbe_pkg::PH_IDLE);
   assign adv       = !is_idle && (delay_ff <= 8'd1);
   assign poll_inc  = {1'b0, poll_ff} + 9'd1;
   assign poll_over = (poll_inc > {1'b0, cfg.ack_poll_limit});
   assign bit_inc   = bit_ff + 4'd1;
   assign shift_rx  = {shift_ff[6:0], tick.sda_in};

   // next state and done pulse
   always_comb begin
      phase_in = phase_ff;
      done     = 1'b0;
      if (step) begin
         if (is_idle) begin
            if (tick.cmd_valid) begin
               case (tick.func)
                  i2cmbe_pkg::FUNC_START:    phase_in = i2cmbe_pkg::PH_ST_A;
                  i2cmbe_pkg::FUNC_STOP:     phase_in = i2cmbe_pkg::PH_SP_A;
                  i2cmbe_pkg::FUNC_SEND:     phase_in = i2cmbe_pkg::PH_TX_HI;
                  i2cmbe_pkg::FUNC_WAIT_ACK: phase_in = i2cmbe_pkg::PH_WA_HI;
                  i2cmbe_pkg::FUNC_READ:     phase_in = i2cmbe_pkg::PH_RX_HI;
                  default:                   phase_in = i2cmbe_pkg::PH_IDLE;
               endcase
            end
         end else if (adv) begin
            case (phase_ff)
               i2cmbe_pkg::PH_ST_A:  phase_in = i2cmbe_pkg::PH_ST_B;
               i2cmbe_pkg::PH_SP_A:  phase_in = i2cmbe_pkg::PH_SP_B;
               i2cmbe_pkg::PH_TX_HI: phase_in = i2cmbe_pkg::PH_TX_LO;
               i2cmbe_pkg::PH_TX_LO: phase_in = i2cmbe_pkg::PH_TX_BIT;
               i2cmbe_pkg::PH_TX_BIT: begin
                  if (bit_ff >= i2cmbe_pkg::BITS_PER_BYTE) begin
                     phase_in = i2cmbe_pkg::PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = i2cmbe_pkg::PH_TX_HI;
                  end
               end
               i2cmbe_pkg::PH_WA_HI: phase_in = i2cmbe_pkg::PH_WA_POLL;
               i2cmbe_pkg::PH_WA_POLL: begin
                  if (!tick.sda_in) begin
                     phase_in = i2cmbe_pkg::PH_IDLE;
                     done     = 1'b1;
                  end else if (poll_over) begin
                     phase_in = i2cmbe_pkg::PH_SP_A;
                  end
               end
               i2cmbe_pkg::PH_RX_HI: phase_in = i2cmbe_pkg::PH_RX_SAMP;
               i2cmbe_pkg::PH_RX_SAMP: begin
                  if (bit_inc < i2cmbe_pkg::BITS_PER_BYTE) begin
                     phase_in = i2cmbe_pkg::PH_RX_HI;
                  end else begin
                     phase_in = i2cmbe_pkg::PH_AK_HI;
                  end
               end
               i2cmbe_pkg::PH_AK_HI: phase_in = i2cmbe_pkg::PH_AK_LO;
               default: begin
                  // end of start, stop and ack bit, and any stray code
                  phase_in = i2cmbe_pkg::PH_IDLE;
                  done     = 1'b1;
               end
            endcase
         end
      end
   end

   // line levels, delay counter and shift datapath
   always_comb begin
      delay_in = delay_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      rcv_in   = rcv_ff;
      poll_in  = poll_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      drv_in   = drv_ff;
      ackc_in  = ackc_ff;
      fail_in  = fail_ff;
      if (step) begin
         if (is_idle) begin
            if (tick.cmd_valid) begin
               case (tick.func)
                  i2cmbe_pkg::FUNC_START: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     drv_in   = 1'b1;
                     delay_in = cfg.long_delay_us;
                  end
                  i2cmbe_pkg::FUNC_STOP: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     drv_in   = 1'b1;
                     delay_in = cfg.long_delay_us;
                  end
                  i2cmbe_pkg::FUNC_SEND: begin
                     // first bit goes out right away
                     scl_in   = 1'b0;
                     drv_in   = 1'b1;
                     sda_in   = tick.tx_byte[7];
                     shift_in = {tick.tx_byte[6:0], 1'b0};
                     bit_in   = 4'd1;
                     delay_in = cfg.short_delay_us;
                  end
                  i2cmbe_pkg::FUNC_WAIT_ACK: begin
                     fail_in  = 1'b0;
                     sda_in   = 1'b1;
                     drv_in   = 1'b0;
                     delay_in = cfg.short_delay_us;
                  end
                  i2cmbe_pkg::FUNC_READ: begin
                     ackc_in  = tick.ack_after_read;
                     sda_in   = 1'b1;
                     drv_in   = 1'b0;
                     shift_in = 8'd0;
                     bit_in   = 4'd0;
                     scl_in   = 1'b0;
                     delay_in = cfg.short_delay_us;
                  end
                  default: delay_in = delay_ff;
               endcase
            end
         end else if (!adv) begin
            delay_in = delay_ff - 8'd1;
         end else begin
            delay_in = 8'd0;
            case (phase_ff)
               i2cmbe_pkg::PH_ST_A: begin
                  sda_in   = 1'b0;
                  delay_in = cfg.long_delay_us;
               end
               i2cmbe_pkg::PH_ST_B: scl_in = 1'b0;
               i2cmbe_pkg::PH_SP_A: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  drv_in   = 1'b1;
                  delay_in = cfg.long_delay_us;
               end
               i2cmbe_pkg::PH_TX_HI: begin
                  scl_in   = 1'b1;
                  delay_in = cfg.short_delay_us;
               end
               i2cmbe_pkg::PH_TX_LO: begin
                  scl_in   = 1'b0;
                  delay_in = cfg.short_delay_us;
               end
               i2cmbe_pkg::PH_TX_BIT: begin
                  if (bit_ff < i2cmbe_pkg::BITS_PER_BYTE) begin
                     sda_in   = shift_ff[7];
                     shift_in = {shift_ff[6:0], 1'b0};
                     bit_in   = bit_inc;
                     delay_in = cfg.short_delay_us;
                  end
               end
               i2cmbe_pkg::PH_WA_HI: begin
                  scl_in   = 1'b1;
                  poll_in  = 8'd0;
                  delay_in = cfg.short_delay_us;
               end
               i2cmbe_pkg::PH_WA_POLL: begin
                  if (!tick.sda_in) begin
                     scl_in  = 1'b0;
                     fail_in = 1'b0;
                  end else if (poll_over) begin
                     // timeout: flag it and fall into the stop sequence
                     fail_in  = 1'b1;
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     drv_in   = 1'b1;
                     delay_in = cfg.long_delay_us;
                  end else begin
                     poll_in = poll_inc[7:0];
                  end
               end
               i2cmbe_pkg::PH_RX_HI: begin
                  scl_in   = 1'b1;
                  delay_in = 8'd1;
               end
               i2cmbe_pkg::PH_RX_SAMP: begin
                  shift_in = shift_rx;
                  bit_in   = bit_inc;
                  if (bit_inc < i2cmbe_pkg::BITS_PER_BYTE) begin
                     scl_in   = 1'b0;
                     delay_in = cfg.short_delay_us;
                  end else begin
                     rcv_in   = shift_rx;
                     scl_in   = 1'b0;
                     sda_in   = !ackc_ff;
                     drv_in   = 1'b1;
                     delay_in = cfg.short_delay_us;
                  end
               end
               i2cmbe_pkg::PH_AK_HI: begin
                  scl_in   = 1'b1;
                  delay_in = cfg.short_delay_us;
               end
               i2cmbe_pkg::PH_AK_LO: scl_in = 1'b0;
               default: delay_in = 8'd0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cmbe_pkg::PH_IDLE;
         delay_ff <= 8'd0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         rcv_ff   <= 8'd0;
         poll_ff  <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drv_ff   <= 1'b0;
         ackc_ff  <= 1'b0;
         fail_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         rcv_ff   <= rcv_in;
         poll_ff  <= poll_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         drv_ff   <= drv_in;
         ackc_ff  <= ackc_in;
         fail_ff  <= fail_in;
      end
   end

   always_comb begin
      res.scl_level  = scl_in;
      res.sda_level  = sda_in;
      res.sda_drive  = drv_in;
      res.busy_res   = (phase_in != i2cmbe_pkg::PH_IDLE);
      res.done_res   = done;
      res.rx_byte    = rcv_in;
      res.ack_failed = fail_in;
   end

endmodule

>>> tb/sv/i2cmbe_bus_checker.sv
// line-state predictor and result checker for the i2c master bit engine
`timescale 1ns / 1ps
module i2cmbe_bus_checker
   import i2cmbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatches,
   output int         lines_pending,
   output logic       seq_busy
);

   logic [7:0] long_dly, short_dly, poll_lim;

   phase_type  ph;
   logic [7:0] dly_cnt;
   logic [3:0] bit_cnt;
   logic [7:0] shreg, rx_reg, poll_cnt;
   logic       scl_q, sda_q, drv_q, ack_sel, fail_q, done_q;

   rsp_type    expected_lines[$];

   function automatic void wait_then(input logic [7:0] ticks, input phase_type nxt);
      dly_cnt = ticks;
      ph = nxt;
   endfunction

   function automatic void end_cmd();
      ph = PH_IDLE;
      dly_cnt = '0;
      done_q = 1'b1;
   endfunction

   function automatic void shift_out_bit();
      sda_q = shreg[7];
      shreg = {shreg[6:0], 1'b0};
      bit_cnt = bit_cnt + 4'd1;
      wait_then(short_dly, PH_TX_HI);
   endfunction

   function automatic void advance_seq(input logic sda_in);
      logic [8:0] polls;
      case (ph)
         PH_ST_A: begin
            sda_q = 1'b0;
            wait_then(long_dly, PH_ST_B);
         end
         PH_ST_B: begin
            scl_q = 1'b0;
            end_cmd();
         end
         PH_SP_A: begin
            scl_q = 1'b1; sda_q = 1'b1; drv_q = 1'b1;
            wait_then(long_dly, PH_SP_B);
         end
         PH_SP_B: end_cmd();
         PH_TX_HI: begin
            scl_q = 1'b1;
            wait_then(short_dly, PH_TX_LO);
         end
         PH_TX_LO: begin
            scl_q = 1'b0;
            wait_then(short_dly, PH_TX_BIT);
         end
         PH_TX_BIT: begin
            if (bit_cnt >= BITS_PER_BYTE) end_cmd();
            else shift_out_bit();
         end
         PH_WA_HI: begin
            scl_q = 1'b1;
            poll_cnt = '0;
            wait_then(short_dly, PH_WA_POLL);
         end
         PH_WA_POLL: begin
            if (!sda_in) begin
               scl_q = 1'b0;
               fail_q = 1'b0;
               end_cmd();
            end else begin
               polls = {1'b0, poll_cnt} + 9'd1;
               if (polls > {1'b0, poll_lim}) begin
                  // no ack in time: flag it and fall into the stop sequence
                  fail_q = 1'b1;
                  scl_q = 1'b0; sda_q = 1'b0; drv_q = 1'b1;
                  wait_then(long_dly, PH_SP_A);
               end else begin
                  poll_cnt = polls[7:0];
                  dly_cnt = '0;
               end
            end
         end
         PH_RX_HI: begin
            scl_q = 1'b1;
            wait_then(8'd1, PH_RX_SAMP);
         end
         PH_RX_SAMP: begin
            shreg = {shreg[6:0], sda_in};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BITS_PER_BYTE) begin
               scl_q = 1'b0;
               wait_then(short_dly, PH_RX_HI);
            end else begin
               rx_reg = shreg;
               scl_q = 1'b0; sda_q = !ack_sel; drv_q = 1'b1;
               wait_then(short_dly, PH_AK_HI);
            end
         end
         PH_AK_HI: begin
            scl_q = 1'b1;
            wait_then(short_dly, PH_AK_LO);
         end
         PH_AK_LO: begin
            scl_q = 1'b0;
            end_cmd();
         end
         default: end_cmd();
      endcase
   endfunction

   function automatic rsp_type predict_lines(input req_type t);
      rsp_type r;
      done_q = 1'b0;
      if (ph == PH_IDLE) begin
         if (t.cmd_valid) begin
            case (t.func)
               FUNC_START: begin
                  scl_q = 1'b1; sda_q = 1'b1; drv_q = 1'b1;
                  wait_then(long_dly, PH_ST_A);
               end
               FUNC_STOP: begin
                  scl_q = 1'b0; sda_q = 1'b0; drv_q = 1'b1;
                  wait_then(long_dly, PH_SP_A);
               end
               FUNC_SEND: begin
                  scl_q = 1'b0; sda_q = 1'b1; drv_q = 1'b1;
                  shreg = t.tx_byte;
                  bit_cnt = '0;
                  shift_out_bit();
               end
               FUNC_WAIT_ACK: begin
                  fail_q = 1'b0;
                  sda_q = 1'b1; drv_q = 1'b0;
                  wait_then(short_dly, PH_WA_HI);
               end
               FUNC_READ: begin
                  ack_sel = t.ack_after_read;
                  sda_q = 1'b1; drv_q = 1'b0;
                  shreg = '0;
                  bit_cnt = '0;
                  scl_q = 1'b0;
                  wait_then(short_dly, PH_RX_HI);
               end
               default: ;
            endcase
         end
      end else if (dly_cnt > 8'd1) begin
         dly_cnt = dly_cnt - 8'd1;
      end else begin
         dly_cnt = '0;
         advance_seq(t.sda_in);
      end
      r.scl_level  = scl_q;
      r.sda_level  = sda_q;
      r.sda_drive  = drv_q;
      r.busy_res   = (ph != PH_IDLE);
      r.done_res   = done_q;
      r.rx_byte    = rx_reg;
      r.ack_failed = fail_q;
      return r;
   endfunction

   task automatic cmp_field(input string name, input logic [7:0] want_v, got_v);
      if (want_v !== got_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         long_dly = LONG_DELAY_RST;
         short_dly = SHORT_DELAY_RST;
         poll_lim = POLL_LIMIT_RST;
         ph = PH_IDLE;
         dly_cnt = '0; bit_cnt = '0; shreg = '0; rx_reg = '0; poll_cnt = '0;
         scl_q = 1'b1; sda_q = 1'b1; drv_q = 1'b0;
         ack_sel = 1'b0; fail_q = 1'b0; done_q = 1'b0;
         expected_lines.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LONG_DELAY:  long_dly = csr_wdata;
               CSR_SHORT_DELAY: short_dly = csr_wdata;
               CSR_POLL_LIMIT:  poll_lim = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_lines.size() == 0) begin
               $error("result item with no expected value");
               mismatches++;
            end else begin
               want = expected_lines.pop_front();
               cmp_field("scl_level", want.scl_level, rsp_data.scl_level);
               cmp_field("sda_level", want.sda_level, rsp_data.sda_level);
               cmp_field("sda_drive", want.sda_drive, rsp_data.sda_drive);
               cmp_field("busy_res", want.busy_res, rsp_data.busy_res);
               cmp_field("done_res", want.done_res, rsp_data.done_res);
               cmp_field("rx_byte", want.rx_byte, rsp_data.rx_byte);
               cmp_field("ack_failed", want.ack_failed, rsp_data.ack_failed);
            end
         end
         if (req_valid && req_ready)
            expected_lines.push_back(predict_lines(req_data));
      end
      lines_pending <= expected_lines.size();
      seq_busy <= (ph != PH_IDLE);
   end

endmodule

>>> tb/sv/tb.sv
// stimulus, handshake idling and verdict for the i2c master bit engine
`timescale 1ns / 1ps
module tb;
   import i2cmbe_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_TICKS = 110;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_LONG_DELAY;
   logic [7:0] csr_wdata = '0;

   int         mismatches, lines_pending;
   logic       seq_busy;
   int         gap_pct = 22;
   int         stall_pct = 72;
   int         sda_pct = 50;
   int         idle_cycles = 0;

   // long, short, poll limit for each random phase
   logic [7:0] cfg_long  [6] = '{8'd1, 8'd3, 8'd60, 8'd2, 8'd0, 8'd1};
   logic [7:0] cfg_short [6] = '{8'd1, 8'd2, 8'd1,  8'd5, 8'd0, 8'd3};
   logic [7:0] cfg_limit [6] = '{8'd1, 8'd6, 8'd2,  8'd255, 8'd0, 8'd255};

   i2c_master_bit_engine_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   i2cmbe_bus_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .lines_pending (lines_pending),
      .seq_busy      (seq_busy)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[i2c_master_bit_engine_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_tick(input req_type t);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // seq_busy trails by one item, so stop only once an idle tick went in on an idle bus
   task automatic drain_seq(input int pct);
      req_type t;
      do begin
         t.cmd_valid = 1'b0;
         t.func = 3'($urandom_range(7));
         t.tx_byte = 8'($urandom);
         t.ack_after_read = 1'($urandom);
         t.sda_in = ($urandom_range(99) < pct);
         send_tick(t);
      end while (seq_busy);
   endtask

   task automatic run_cmd(input logic [2:0] func, input logic [7:0] tx, input logic ack,
                          input int pct);
      req_type t;
      t.cmd_valid = 1'b1;
      t.func = func;
      t.tx_byte = tx;
      t.ack_after_read = ack;
      t.sda_in = ($urandom_range(99) < pct);
      send_tick(t);
      drain_seq(pct);
   endtask

   // lines_pending is registered, so let it catch up with the last accepted item first
   task automatic settle_bus();
      req_valid <= 1'b0;
      @(posedge clock);
      while (lines_pending != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] long_v, short_v, limit_v);
      write_csr(CSR_LONG_DELAY, long_v);
      write_csr(CSR_SHORT_DELAY, short_v);
      write_csr(CSR_POLL_LIMIT, limit_v);
      csr_valid <= 1'b0;
   endtask

   task automatic random_ticks(input int count);
      req_type t;
      logic    last_cmd;
      int      pick;
      int      n;
      last_cmd = 1'b0;
      for (n = 0; n < count; n++) begin
         t.cmd_valid = 1'b0;
         t.func = 3'($urandom_range(7));
         t.tx_byte = 8'($urandom);
         t.ack_after_read = 1'($urandom);
         if (!seq_busy && !last_cmd && $urandom_range(2) == 0) begin
            t.cmd_valid = 1'b1;
            t.func = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5))
                                               : 3'($urandom_range(4));
            pick = $urandom_range(2);
            sda_pct = (pick == 0) ? 100 : (pick == 1) ? 80 : 35;
         end else if ($urandom_range(39) == 0) begin
            t.cmd_valid = 1'b1;  // mostly lands while busy and gets dropped
         end
         t.sda_in = ($urandom_range(99) < sda_pct);
         last_cmd = t.cmd_valid;
         send_tick(t);
      end
   endtask

   initial begin
      req_type t;
      int      phase_i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass on reset register values
      run_cmd(FUNC_START, 8'h00, 1'b0, 50);
      run_cmd(FUNC_SEND, 8'h00, 1'b0, 50);
      run_cmd(FUNC_SEND, 8'hff, 1'b1, 50);
      run_cmd(FUNC_SEND, 8'ha5, 1'b0, 50);
      run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 0);
      run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 100);
      run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 0);
      run_cmd(FUNC_READ, 8'h00, 1'b1, 100);
      run_cmd(FUNC_READ, 8'hff, 1'b0, 0);
      run_cmd(FUNC_READ, 8'h3c, 1'b1, 50);
      run_cmd(FUNC_STOP, 8'h00, 1'b0, 50);
      run_cmd(3'd5, 8'hff, 1'b1, 50);
      run_cmd(3'd6, 8'h00, 1'b0, 50);
      run_cmd(3'd7, 8'h81, 1'b1, 50);

      // second command offered while the start is still running
      t.cmd_valid = 1'b1;
      t.func = FUNC_START;
      t.tx_byte = 8'h00;
      t.ack_after_read = 1'b0;
      t.sda_in = 1'b1;
      send_tick(t);
      t.func = FUNC_STOP;
      send_tick(t);
      drain_seq(50);

      // zero registers act as one tick, zero poll limit fails on the first high poll
      settle_bus();
      set_config(8'd0, 8'd0, 8'd0);
      run_cmd(FUNC_START, 8'h00, 1'b0, 50);
      run_cmd(FUNC_SEND, 8'h5a, 1'b0, 50);
      run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 100);
      run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 0);
      run_cmd(FUNC_READ, 8'h00, 1'b0, 50);
      run_cmd(FUNC_STOP, 8'h00, 1'b1, 50);

      // long delay rewritten while a stop is part way through
      settle_bus();
      set_config(8'd3, 8'd2, 8'd4);
      t.cmd_valid = 1'b1;
      t.func = FUNC_STOP;
      t.sda_in = 1'b0;
      send_tick(t);
      t.cmd_valid = 1'b0;
      send_tick(t);
      send_tick(t);
      settle_bus();
      write_csr(CSR_LONG_DELAY, 8'd9);
      csr_valid <= 1'b0;
      drain_seq(50);

      for (phase_i = 0; phase_i < 6; phase_i++) begin
         gap_pct = (phase_i < 2) ? 22 : (phase_i < 4) ? 72 : 0;
         stall_pct = (phase_i < 2) ? 72 : (phase_i < 4) ? 22 : 0;
         settle_bus();
         set_config(cfg_long[phase_i], cfg_short[phase_i], cfg_limit[phase_i]);
         random_ticks(RANDOM_TICKS);
         drain_seq(0);
      end

      settle_bus();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && lines_pending == 0) begin
         $display("[i2c_master_bit_engine_top] OK");
      end else begin
         $display("[i2c_master_bit_engine_top] ERROR");
      end
      $finish;
   end

endmodule
